[sv/mrcs_pkg.sv]
// mrcs_pkg: shared types and constants of the min-rtt clock offset sync unit
// used by mrcs_front, mrcs_state and min_rtt_clock_offset_sync_unit; no dependencies
package mrcs_pkg;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 63;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_SYNC_ENABLE       = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RESYNC_INTERVAL   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLES_PER_ROUND = 2'd2;

	localparam logic [62:0] RESYNC_INTERVAL_RESET = 63'd200000000;
	localparam logic [7:0]  SAMPLES_PER_ROUND_RESET = 8'd20;

	typedef enum logic {
		OP_QUERY  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic {
		STATUS_OK      = 1'b0,
		STATUS_IGNORED = 1'b1
	} status_t;

	typedef struct packed {
		logic valid;
		op_t  op;
		logic try_resync;
	} ctl_t;

endpackage

[sv/mrcs_front.sv]
// mrcs_front: two input stages doing the state-independent sample arithmetic
// (round trip, send minus remote, candidate offset); depends on mrcs_pkg
module mrcs_front #(
	parameter int TIME_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic                    operation,
	input  logic                    try_resync,
	input  logic [63:0]             now_local,
	input  logic [63:0]             send_time,
	input  logic [63:0]             remote_time,
	input  logic [63:0]             receive_time,
	input  logic                    adv_out,
	output mrcs_pkg::ctl_t          ctl_s2,
	output logic [TIME_BITS-1:0]    now_s2,
	output logic [TIME_BITS-1:0]    rtt_s2,
	output logic [TIME_BITS-1:0]    cand_s2,
	output logic [TIME_BITS-1:0]    t3_s2
);
	import mrcs_pkg::*;

	ctl_t                 ctl_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [TIME_BITS-1:0] rtt_s1;
	logic [TIME_BITS-1:0] d12_s1;
	logic [TIME_BITS-1:0] t3_s1;

	logic [TIME_BITS-1:0] t1_c;
	logic [TIME_BITS-1:0] t2_c;
	logic [TIME_BITS-1:0] t3_c;
	logic [TIME_BITS-1:0] half_c;
	logic                 adv_s1;
	logic                 adv_s2;

	assign t1_c = send_time[TIME_BITS-1:0];
	assign t2_c = remote_time[TIME_BITS-1:0];
	assign t3_c = receive_time[TIME_BITS-1:0];

	assign adv_s2     = !ctl_s2.valid || adv_out;
	assign adv_s1     = !ctl_s1.valid || adv_s2;
	assign item_ready = adv_s1;

	// halving toward zero: arithmetic shift here; the plus one when negative and odd is added in cand_s2
	assign half_c = TIME_BITS'($signed(rtt_s1) >>> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			if (adv_s1) begin
				ctl_s1.valid      <= item_valid;
				ctl_s1.op         <= op_t'(operation);
				ctl_s1.try_resync <= try_resync;
			end
			if (adv_s2) begin
				ctl_s2 <= ctl_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			now_s1 <= now_local[TIME_BITS-1:0];
			rtt_s1 <= t3_c - t1_c;
			d12_s1 <= t1_c - t2_c;
			t3_s1  <= t3_c;
		end
		if (adv_s2 && ctl_s1.valid) begin
			now_s2  <= now_s1;
			rtt_s2  <= rtt_s1;
			cand_s2 <= d12_s1 + half_c + TIME_BITS'(rtt_s1[TIME_BITS-1] & rtt_s1[0]);
			t3_s2   <= t3_s1;
		end
	end

endmodule

[sv/mrcs_state.sv]
// mrcs_state: configuration registers, round state and the result register
// takes the prepared word from mrcs_front; depends on mrcs_pkg
module mrcs_state #(
	parameter int TIME_BITS  = 64,
	parameter int COUNT_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write_en,
	input  logic [mrcs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mrcs_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  mrcs_pkg::ctl_t                        ctl_s2,
	input  logic [TIME_BITS-1:0]                  now_s2,
	input  logic [TIME_BITS-1:0]                  rtt_s2,
	input  logic [TIME_BITS-1:0]                  cand_s2,
	input  logic [TIME_BITS-1:0]                  t3_s2,
	output logic                                  adv_out,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [63:0]                    clock_offset,
	output logic                                  resync_request,
	output logic                                  round_complete,
	output logic signed [63:0]                    offset_drift,
	output logic                                  item_status
);
	import mrcs_pkg::*;

	localparam int CW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
	localparam logic [TIME_BITS-1:0]  TMAX = {1'b0, {(TIME_BITS-1){1'b1}}};
	localparam logic [TIME_BITS-1:0]  TMIN = {1'b1, {(TIME_BITS-1){1'b0}}};
	localparam logic [TIME_BITS-1:0]  BEST_OFF_INIT = TMAX >> 1;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	logic                  sync_enable_q;
	logic [62:0]           interval_q;
	logic [7:0]            samples_q;

	logic [TIME_BITS-1:0]  offset_q;
	logic [TIME_BITS-1:0]  sync_stamp_q;
	logic [TIME_BITS-1:0]  best_rtt_q;
	logic [TIME_BITS-1:0]  best_off_q;
	logic [COUNT_BITS-1:0] seen_q;
	logic                  busy_q;

	logic                  result_valid_q;
	logic signed [63:0]    clock_offset_q;
	logic                  resync_request_q;
	logic                  round_complete_q;
	logic signed [63:0]    offset_drift_q;
	status_t               item_status_q;

	logic                  take;
	logic                  is_query;
	logic [TIME_BITS-1:0]  gap_c;
	logic                  start;
	logic                  lt;
	logic [TIME_BITS-1:0]  new_best_rtt;
	logic [TIME_BITS-1:0]  new_best_off;
	logic [COUNT_BITS-1:0] seen_inc;
	logic [CW-1:0]         target;
	logic                  done;
	logic                  ignored;
	logic [TIME_BITS-1:0]  new_off;
	logic [TIME_BITS-1:0]  drift;

	assign adv_out  = !result_valid_q || result_ready;
	assign take     = ctl_s2.valid && adv_out;
	assign is_query = (ctl_s2.op == OP_QUERY);

	assign gap_c = now_s2 - sync_stamp_q;
	assign start = is_query && ctl_s2.try_resync && sync_enable_q && !busy_q &&
		($signed(sync_stamp_q) < $signed(now_s2)) && (64'(gap_c) > 64'(interval_q));

	assign lt           = $signed(rtt_s2) < $signed(best_rtt_q);
	assign new_best_rtt = lt ? rtt_s2 : best_rtt_q;
	assign new_best_off = lt ? cand_s2 : best_off_q;
	assign seen_inc     = (seen_q != CMAX) ? seen_q + 1'b1 : seen_q;

	always_comb begin
		if (CW'(samples_q) == '0) begin
			target = CW'(1);
		end else if (CW'(samples_q) > CW'(CMAX)) begin
			target = CW'(CMAX);
		end else begin
			target = CW'(samples_q);
		end
	end

	assign ignored = !is_query && !busy_q;
	assign done    = !is_query && busy_q && (CW'(seen_inc) >= target);
	assign new_off = done ? new_best_off : offset_q;
	assign drift   = done ? offset_q - new_best_off : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_enable_q <= 1'b0;
			interval_q    <= RESYNC_INTERVAL_RESET;
			samples_q     <= SAMPLES_PER_ROUND_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_SYNC_ENABLE:       sync_enable_q <= cfg_data[0];
				CFG_RESYNC_INTERVAL:   interval_q    <= cfg_data;
				CFG_SAMPLES_PER_ROUND: samples_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= '0;
			sync_stamp_q <= TMIN;
			best_rtt_q   <= TMAX;
			best_off_q   <= BEST_OFF_INIT;
			seen_q       <= '0;
			busy_q       <= 1'b0;
		end else if (take) begin
			if (start) begin
				busy_q     <= 1'b1;
				seen_q     <= '0;
				best_rtt_q <= TMAX;
				best_off_q <= BEST_OFF_INIT;
			end else if (!is_query && busy_q) begin
				best_rtt_q <= new_best_rtt;
				best_off_q <= new_best_off;
				seen_q     <= seen_inc;
				if (done) begin
					offset_q     <= new_best_off;
					sync_stamp_q <= t3_s2;
					busy_q       <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_out) begin
			result_valid_q <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			clock_offset_q   <= 64'($signed(new_off));
			resync_request_q <= start;
			round_complete_q <= done;
			offset_drift_q   <= 64'($signed(drift));
			item_status_q    <= ignored ? STATUS_IGNORED : STATUS_OK;
		end
	end

	assign result_valid   = result_valid_q;
	assign clock_offset   = clock_offset_q;
	assign resync_request = resync_request_q;
	assign round_complete = round_complete_q;
	assign offset_drift   = offset_drift_q;
	assign item_status    = item_status_q;

	a_ignored_is_plain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (item_status_q == STATUS_IGNORED)
		|-> !round_complete_q && !resync_request_q)
		else $error("ignored sample word carries a round event");

	a_drift_only_on_complete: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !round_complete_q |-> offset_drift_q == '0)
		else $error("drift reported without round completion");

	a_round_starts_with_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> result_valid_q && resync_request_q)
		else $error("round started without a resync request");

	a_round_ends_with_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> result_valid_q && round_complete_q)
		else $error("round ended without round completion");

endmodule

[sv/min_rtt_clock_offset_sync_unit.sv]
// min_rtt_clock_offset_sync_unit: top level, front stages plus state and result register
// an accepted input word passes stage s1, stage s2 and the result register before its result is valid
// throughput: one word per cycle while the result is not stalled, set by the two input stages and the result register
// a stalled result holds the pipeline; a new word is still taken while stages are free
// reset: arst_n asynchronous, clears pipeline valids, round state and configuration
// depends on mrcs_pkg, mrcs_front, mrcs_state
module min_rtt_clock_offset_sync_unit #(
	parameter int TIME_BITS  = 64,
	parameter int COUNT_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write_en,
	input  logic [mrcs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mrcs_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic                                  operation,
	input  logic                                  try_resync,
	input  logic signed [63:0]                    now_local,
	input  logic signed [63:0]                    send_time,
	input  logic signed [63:0]                    remote_time,
	input  logic signed [63:0]                    receive_time,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [63:0]                    clock_offset,
	output logic                                  resync_request,
	output logic                                  round_complete,
	output logic signed [63:0]                    offset_drift,
	output logic                                  item_status
);
	import mrcs_pkg::*;

	ctl_t                 ctl_s2;
	logic [TIME_BITS-1:0] now_s2;
	logic [TIME_BITS-1:0] rtt_s2;
	logic [TIME_BITS-1:0] cand_s2;
	logic [TIME_BITS-1:0] t3_s2;
	logic                 adv_out;

	mrcs_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.try_resync   (try_resync),
		.now_local    (now_local),
		.send_time    (send_time),
		.remote_time  (remote_time),
		.receive_time (receive_time),
		.adv_out      (adv_out),
		.ctl_s2       (ctl_s2),
		.now_s2       (now_s2),
		.rtt_s2       (rtt_s2),
		.cand_s2      (cand_s2),
		.t3_s2        (t3_s2)
	);

	mrcs_state #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.ctl_s2         (ctl_s2),
		.now_s2         (now_s2),
		.rtt_s2         (rtt_s2),
		.cand_s2        (cand_s2),
		.t3_s2          (t3_s2),
		.adv_out        (adv_out),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.clock_offset   (clock_offset),
		.resync_request (resync_request),
		.round_complete (round_complete),
		.offset_drift   (offset_drift),
		.item_status    (item_status)
	);

endmodule
